// File: design/bhfa_pkg.sv
package bhfa_pkg;

   // item kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_NODE   = 2'd1;
   localparam logic [1:0] KIND_BODY   = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   // result decisions
   localparam logic [1:0] DEC_ACCUM   = 2'd0;
   localparam logic [1:0] DEC_DESCEND = 2'd1;
   localparam logic [1:0] DEC_EXPAND  = 2'd2;
   localparam logic [1:0] DEC_ACK     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_THETA_SQ   = 2'd0;
   localparam logic [1:0] CSR_SOFT_SQ    = 2'd1;
   localparam logic [1:0] CSR_GRAV_CONST = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   // register reset values
   localparam logic [15:0] THETA_SQ_RST   = 16'd1024;
   localparam logic [47:0] SOFT_SQ_RST    = 48'd65536;
   localparam logic [31:0] GRAV_CONST_RST = 32'd65536;

   // accumulator limits, Q24.24
   localparam logic [47:0] TERM_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] ACC_MIN  = 48'h8000_0000_0000;

   // serial multiplier: one multiplier bit per cycle
   localparam int MUL_A_W   = 66;
   localparam int MUL_B_W   = 33;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // serial square root: two radicand bits per cycle
   localparam int SQRT_V_W   = 64;
   localparam int SQRT_R_W   = SQRT_V_W / 2;
   localparam int SQRT_CNT_W = $clog2(SQRT_R_W);

   // serial divider: one quotient bit per cycle
   localparam int DIV_N_W   = 97;
   localparam int DIV_D_W   = 84;
   localparam int DIV_Q_W   = 47;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

endpackage

// File: design/bhfa_if.sv
interface bhfa_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  kind;
   logic signed [31:0] item_x;
   logic signed [31:0] item_y;
   logic        [31:0] item_mass;
   logic        [31:0] node_size;
   logic               node_is_leaf;

   modport source (output valid, kind, item_x, item_y, item_mass, node_size, node_is_leaf,
                   input ready);
   modport sink   (input valid, kind, item_x, item_y, item_mass, node_size, node_is_leaf,
                   output ready);
endinterface

interface bhfa_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  decision;
   logic signed [47:0] accel_x;
   logic signed [47:0] accel_y;
   logic               saturated;

   modport source (output valid, decision, accel_x, accel_y, saturated, input ready);
   modport sink   (input valid, decision, accel_x, accel_y, saturated, output ready);
endinterface

interface bhfa_csr_if;
   import bhfa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/bhfa_mul.sv
module bhfa_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bhfa_pkg::MUL_A_W-1:0]  a,
   input  logic [bhfa_pkg::MUL_B_W-1:0]  b,
   output logic                          done,
   output logic [bhfa_pkg::MUL_P_W-1:0]  prod
);
   import bhfa_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_A_W-1:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]   lo_ff, lo_in;
   logic [MUL_A_W:0]     sum;

   // shift-add step, multiplier bits lsb first
   always_comb begin
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = a;
         hi_in    = '0;
         lo_in    = b;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_A_W:1];
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};
endmodule

// File: design/bhfa_sqrt.sv
module bhfa_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bhfa_pkg::SQRT_V_W-1:0] value,
   output logic                          done,
   output logic [bhfa_pkg::SQRT_R_W-1:0] root
);
   import bhfa_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQRT_V_W-1:0]   rad_ff, rad_in;
   logic [SQRT_R_W+1:0]   rem_ff, rem_in;
   logic [SQRT_R_W-1:0]   root_ff, root_in;
   logic [SQRT_R_W+3:0]   part, trial, diff;

   // digit-by-digit root, two radicand bits per step
   always_comb begin
      part    = {rem_ff, rad_ff[SQRT_V_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = part - trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQRT_V_W-3:0], 2'b00};
         if (part >= trial) begin
            rem_in  = diff[SQRT_R_W+1:0];
            root_in = {root_ff[SQRT_R_W-2:0], 1'b1};
         end else begin
            rem_in  = part[SQRT_R_W+1:0];
            root_in = {root_ff[SQRT_R_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_W'(SQRT_R_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// File: design/bhfa_div.sv
module bhfa_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bhfa_pkg::DIV_N_W-1:0] num,
   input  logic [bhfa_pkg::DIV_D_W-1:0] den,
   output logic                         done,
   output logic                         ovf,
   output logic [bhfa_pkg::DIV_Q_W-1:0] quo
);
   import bhfa_pkg::*;

   localparam int WIDE_W = DIV_D_W + DIV_Q_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W:0]     part, diff;
   logic                 too_big;

   // quotient beyond its width when num >= den * 2^q
   assign too_big = WIDE_W'(num) >= {den, {DIV_Q_W{1'b0}}};

   // restoring division, one quotient bit per step
   always_comb begin
      part    = {rem_ff, low_ff[DIV_Q_W-1]};
      diff    = part - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = '0;
         den_in = den;
         rem_in = DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]);
         low_in = num[DIV_Q_W-1:0];
         quo_in = '0;
         ovf_in = too_big;
         if (too_big) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         low_in = {low_ff[DIV_Q_W-2:0], 1'b0};
         if (part >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = part[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quo  = quo_ff;
endmodule

// File: design/barnes_hut_force_accumulator_top.sv
// Barnes-Hut 2D force accumulator for one target body.
// req_ch carries items: start (loads target, clears accumulators), tree node
// (opening test, then approximated pull or a descend/expand decision), leaf
// body (always pulled) and finish (returns accel_x/accel_y in Q24.24).
// rsp_ch returns exactly one result per item; saturated is the clip flag.
// csr_ch writes theta_sq (0), soft_sq (1) and grav_const (2); it is always
// ready and must only be written while the block is idle.
// One item is worked at a time. Start and finish results pass from the idle
// state through the done state into the output register. Every product goes
// through one shared shift-add multiplier, the root is formed at two bits a
// cycle, and each axis quotient is formed at one bit a cycle.
// The result sits in an output register; while the receiver stalls, the
// next item may be taken and worked, and it waits for the register to free.
// Synchronous reset returns the registers to their defaults, clears target,
// accumulators and clip flag, and drops rsp valid.
module barnes_hut_force_accumulator_top (
   input  logic       clock,
   input  logic       reset,
   bhfa_req_if.sink   req_ch,
   bhfa_rsp_if.source rsp_ch,
   bhfa_csr_if.sink   csr_ch
);
   import bhfa_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQX  = 4'd1;
   localparam logic [3:0] S_SQY  = 4'd2;
   localparam logic [3:0] S_SZ   = 4'd3;
   localparam logic [3:0] S_TH   = 4'd4;
   localparam logic [3:0] S_PULL = 4'd5;
   localparam logic [3:0] S_SQRT = 4'd6;
   localparam logic [3:0] S_DEN  = 4'd7;
   localparam logic [3:0] S_GM   = 4'd8;
   localparam logic [3:0] S_NX   = 4'd9;
   localparam logic [3:0] S_DX   = 4'd10;
   localparam logic [3:0] S_NY   = 4'd11;
   localparam logic [3:0] S_DY   = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic        launched_ff, launched_in;
   logic [15:0] theta_ff, theta_in;
   logic [47:0] soft_ff, soft_in;
   logic [31:0] grav_ff, grav_in;
   logic [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [47:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic        clip_ff, clip_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_dec_ff, rsp_dec_in;
   logic [47:0] rsp_ax_ff, rsp_ax_in, rsp_ay_ff, rsp_ay_in;
   logic        rsp_sat_ff, rsp_sat_in;

   logic [1:0]  kind_ff, kind_in;
   logic        leaf_ff, leaf_in;
   logic [31:0] mass_ff, mass_in, size_ff, size_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic [32:0] mx_ff, mx_in, my_ff, my_in;
   logic [65:0] d2_ff, d2_in;
   logic [63:0] ss_ff, ss_in;
   logic [49:0] dd_ff, dd_in;
   logic [31:0] root_ff, root_in;
   logic [83:0] den_ff, den_in;
   logic [63:0] gm_ff, gm_in;
   logic [1:0]  res_dec_ff, res_dec_in;
   logic [47:0] res_ax_ff, res_ax_in, res_ay_ff, res_ay_in;

   logic [32:0]        rx, ry;
   logic               is_mul;
   logic               mul_start, sqrt_start, div_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic               mul_done, sqrt_done, div_done, div_ovf;
   logic [MUL_P_W-1:0] mul_prod;
   logic [SQRT_R_W-1:0] sqrt_root;
   logic [DIV_Q_W-1:0] div_quo;
   logic [50:0]        dd_sum;
   logic [81:0]        open_lhs;
   logic [47:0]        acc_sel, term, acc_new;
   logic               neg_sel, acc_clip;
   logic [48:0]        acc_sum;

   // shared arithmetic units
   bhfa_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_prod)
   );

   bhfa_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sqrt_start),
      .value ({dd_ff, 14'd0}), .done (sqrt_done), .root (sqrt_root)
   );

   bhfa_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (mul_prod[DIV_N_W-1:0]), .den (den_ff),
      .done (div_done), .ovf (div_ovf), .quo (div_quo)
   );

   // offsets from target, 33 bit exact
   assign rx = {req_ch.item_x[31], req_ch.item_x} - {tx_ff[31], tx_ff};
   assign ry = {req_ch.item_y[31], req_ch.item_y} - {ty_ff[31], ty_ff};

   assign is_mul     = state_ff inside {S_SQX, S_SQY, S_SZ, S_TH, S_DEN, S_GM, S_NX, S_NY};
   assign mul_start  = is_mul && !launched_ff;
   assign sqrt_start = (state_ff == S_SQRT) && !launched_ff;
   assign div_start  = ((state_ff == S_DX) || (state_ff == S_DY)) && !launched_ff;

   // multiplier operand select
   always_comb begin
      case (state_ff)
         S_SQX: begin mul_a = MUL_A_W'(mx_ff);   mul_b = mx_ff;                  end
         S_SQY: begin mul_a = MUL_A_W'(my_ff);   mul_b = my_ff;                  end
         S_SZ:  begin mul_a = MUL_A_W'(size_ff); mul_b = MUL_B_W'(size_ff);      end
         S_TH:  begin mul_a = d2_ff;             mul_b = MUL_B_W'(theta_ff);     end
         S_DEN: begin mul_a = MUL_A_W'(dd_ff);   mul_b = MUL_B_W'(root_ff);      end
         S_GM:  begin mul_a = MUL_A_W'(grav_ff); mul_b = MUL_B_W'(mass_ff);      end
         S_NX:  begin mul_a = MUL_A_W'(gm_ff);   mul_b = mx_ff;                  end
         S_NY:  begin mul_a = MUL_A_W'(gm_ff);   mul_b = my_ff;                  end
         default: begin mul_a = '0;              mul_b = '0;                     end
      endcase
   end

   // softened distance, below 2^50 for all inputs
   assign dd_sum   = {1'b0, d2_ff[65:16]} + {3'b000, soft_ff};
   assign open_lhs = {6'd0, ss_ff, 12'd0};

   // signed, saturating accumulate of one axis term
   assign acc_sel = (state_ff == S_DX) ? acc_x_ff : acc_y_ff;
   assign neg_sel = (state_ff == S_DX) ? sx_ff : sy_ff;
   assign term    = div_ovf ? TERM_MAX : {1'b0, div_quo};
   assign acc_sum = {acc_sel[47], acc_sel}
                  + (neg_sel ? (~{1'b0, term} + 49'd1) : {1'b0, term});

   always_comb begin
      acc_clip = div_ovf;
      acc_new  = acc_sum[47:0];
      if (!acc_sum[48] && acc_sum[47]) begin
         acc_new  = TERM_MAX;
         acc_clip = 1'b1;
      end else if (acc_sum[48] && !acc_sum[47]) begin
         acc_new  = ACC_MIN;
         acc_clip = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      theta_in     = theta_ff;
      soft_in      = soft_ff;
      grav_in      = grav_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dec_in   = rsp_dec_ff;
      rsp_ax_in    = rsp_ax_ff;
      rsp_ay_in    = rsp_ay_ff;
      rsp_sat_in   = rsp_sat_ff;
      kind_in      = kind_ff;
      leaf_in      = leaf_ff;
      mass_in      = mass_ff;
      size_in      = size_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      d2_in        = d2_ff;
      ss_in        = ss_ff;
      dd_in        = dd_ff;
      root_in      = root_ff;
      den_in       = den_ff;
      gm_in        = gm_ff;
      res_dec_in   = res_dec_ff;
      res_ax_in    = res_ax_ff;
      res_ay_in    = res_ay_ff;

      // register writes
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_THETA_SQ:   theta_in = csr_ch.data[15:0];
            CSR_SOFT_SQ:    soft_in  = csr_ch.data;
            CSR_GRAV_CONST: grav_in  = csr_ch.data[31:0];
            default: ;
         endcase
      end

      if (mul_start || sqrt_start || div_start) begin
         launched_in = 1'b1;
      end
      if (mul_done || sqrt_done || div_done) begin
         launched_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in   = req_ch.kind;
               leaf_in   = req_ch.node_is_leaf;
               mass_in   = req_ch.item_mass;
               size_in   = req_ch.node_size;
               sx_in     = rx[32];
               sy_in     = ry[32];
               mx_in     = rx[32] ? (~rx + 33'd1) : rx;
               my_in     = ry[32] ? (~ry + 33'd1) : ry;
               res_ax_in = '0;
               res_ay_in = '0;
               case (req_ch.kind)
                  KIND_START: begin
                     tx_in      = req_ch.item_x;
                     ty_in      = req_ch.item_y;
                     acc_x_in   = '0;
                     acc_y_in   = '0;
                     clip_in    = 1'b0;
                     res_dec_in = DEC_ACK;
                     state_in   = S_DONE;
                  end
                  KIND_FINISH: begin
                     res_dec_in = DEC_ACK;
                     res_ax_in  = acc_x_ff;
                     res_ay_in  = acc_y_ff;
                     state_in   = S_DONE;
                  end
                  default: state_in = S_SQX;
               endcase
            end
         end
         S_SQX: begin
            if (mul_done) begin
               d2_in    = mul_prod[65:0];
               state_in = S_SQY;
            end
         end
         S_SQY: begin
            if (mul_done) begin
               d2_in    = d2_ff + mul_prod[65:0];
               state_in = (kind_ff == KIND_NODE) ? S_SZ : S_PULL;
            end
         end
         S_SZ: begin
            if (mul_done) begin
               ss_in    = mul_prod[63:0];
               state_in = S_TH;
            end
         end
         S_TH: begin
            // opening test: size^2 * 2^12 < theta_sq * d^2
            if (mul_done) begin
               if (open_lhs < mul_prod[81:0]) begin
                  state_in = S_PULL;
               end else begin
                  res_dec_in = leaf_ff ? DEC_EXPAND : DEC_DESCEND;
                  state_in   = S_DONE;
               end
            end
         end
         S_PULL: begin
            dd_in      = dd_sum[49:0];
            res_dec_in = DEC_ACCUM;
            state_in   = (dd_sum == '0) ? S_DONE : S_SQRT;
         end
         S_SQRT: begin
            if (sqrt_done) begin
               root_in  = sqrt_root;
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (mul_done) begin
               den_in   = {mul_prod[82:0], 1'b0};
               state_in = S_GM;
            end
         end
         S_GM: begin
            if (mul_done) begin
               gm_in    = mul_prod[63:0];
               state_in = S_NX;
            end
         end
         S_NX: begin
            if (mul_done) begin
               state_in = S_DX;
            end
         end
         S_DX: begin
            if (div_done) begin
               acc_x_in = acc_new;
               clip_in  = clip_ff | acc_clip;
               state_in = S_NY;
            end
         end
         S_NY: begin
            if (mul_done) begin
               state_in = S_DY;
            end
         end
         S_DY: begin
            if (div_done) begin
               acc_y_in = acc_new;
               clip_in  = clip_ff | acc_clip;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dec_in   = res_dec_ff;
               rsp_ax_in    = res_ax_ff;
               rsp_ay_in    = res_ay_ff;
               rsp_sat_in   = clip_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         theta_ff     <= THETA_SQ_RST;
         soft_ff      <= SOFT_SQ_RST;
         grav_ff      <= GRAV_CONST_RST;
         tx_ff        <= '0;
         ty_ff        <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         theta_ff     <= theta_in;
         soft_ff      <= soft_in;
         grav_ff      <= grav_in;
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      rsp_dec_ff <= rsp_dec_in;
      rsp_ax_ff  <= rsp_ax_in;
      rsp_ay_ff  <= rsp_ay_in;
      rsp_sat_ff <= rsp_sat_in;
      kind_ff    <= kind_in;
      leaf_ff    <= leaf_in;
      mass_ff    <= mass_in;
      size_ff    <= size_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      d2_ff      <= d2_in;
      ss_ff      <= ss_in;
      dd_ff      <= dd_in;
      root_ff    <= root_in;
      den_ff     <= den_in;
      gm_ff      <= gm_in;
      res_dec_ff <= res_dec_in;
      res_ax_ff  <= res_ax_in;
      res_ay_ff  <= res_ay_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.decision  = rsp_dec_ff;
   assign rsp_ch.accel_x   = rsp_ax_ff;
   assign rsp_ch.accel_y   = rsp_ay_ff;
   assign rsp_ch.saturated = rsp_sat_ff;
endmodule
